@@ design/ekbt_pkg.sv @@
// Package: shared constants and types for the expiring key blocklist table.
`timescale 1ns / 1ps
package ekbt_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_LIFETIME = 2'd1;
  localparam logic [1:0] REG_KEYBYTES = 2'd2;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [31:0]          expiry;
  } entry_t;
endpackage

@@ design/ekbt_mem.sv @@
// Module: entry memory with one write and one registered read port.
`timescale 1ns / 1ps
module ekbt_mem
  import ekbt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);
  entry_t mem [TABLE_DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ design/expiring_key_blocklist_table_unit.sv @@
// Top level: expiring key blocklist table with sequential scan over an entry memory.
//
// Usage: one input channel (op, key, value_size, now_seconds) and one result
// channel (status, found, removed_count, occupancy), both valid/ready. One
// result transaction per input transaction, in order.
// Each item is handled by a walk over the entry memory, one slot per cycle
// through its single read port. An add or query that hits ends the walk
// early, after the matching slot is re-read for its stored key. A new item
// is accepted in the idle state once the result of the last one is
// registered, so items are never walked in overlap. The valid bit of each
// slot lives in flip-flops; keys and expiry in the memory, size is never
// read back and so is not stored.
// Reset clears valid bits, the count and the registers (capacity 64,
// lifetime 0, key_bytes 8); no clearing pass is needed.
// If the receiver stalls, the result is held in the output register; one
// new item may still be accepted and walked, and it then waits in the final
// state, with no table update, until the held result is taken.
// Configuration: APB, registers at 0x0, 0x4, 0x8; pready always high.
module expiring_key_blocklist_table_unit
  import ekbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] key,
  input  logic [31:0] value_size,
  input  logic [31:0] now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        found,
  output logic [6:0]  removed_count,
  output logic [6:0]  occupancy
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t               state;
  logic [6:0]           capacity_limit;
  logic [31:0]          lifetime_seconds;
  logic [3:0]           key_bytes;
  logic [TABLE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]     count;
  logic [1:0]           cur_op;
  logic [KEY_WIDTH-1:0] cur_key;
  logic [KEY_WIDTH-1:0] mask;
  logic [31:0]          cur_now;
  logic [IDX_W:0]       raddr;      // address issued
  logic                 rd_vld;
  logic [IDX_W-1:0]     ridx;       // address of data in rdata
  logic                 hit;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free;
  logic [IDX_W-1:0]     free_idx;
  logic [CNT_W-1:0]     removed;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  entry_t               wdata;
  entry_t               rdata;
  logic [1:0]           cfg_idx;
  logic [3:0]           kb;
  logic [CNT_W-1:0]     cap_eff;
  logic [IDX_W-1:0]     mem_raddr;
  logic                 fin_go;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign in_ready = (state == S_IDLE);
  // Commit the item only once the output register is free.
  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    case (cfg_idx)
      REG_CAPACITY: prdata = {25'd0, capacity_limit};
      REG_LIFETIME: prdata = lifetime_seconds;
      REG_KEYBYTES: prdata = {28'd0, key_bytes};
      default:      prdata = 32'd0;
    endcase
  end

  // Effective key byte count and capacity.
  always_comb begin
    kb = key_bytes;
    if (kb == 4'd0) kb = 4'd1;
    if (kb > 4'd8)  kb = 4'd8;
    for (int b = 0; b < KEY_WIDTH; b++) begin
      mask[b] = (b < 8 * int'(kb));
    end
    if (int'(capacity_limit) > TABLE_DEPTH) cap_eff = CNT_W'(TABLE_DEPTH);
    else cap_eff = CNT_W'(capacity_limit);
  end

  logic match;
  assign match = valid[ridx] && ((rdata.key & mask) == cur_key);

  // Hold the read on the hit slot so its stored key is at hand for the refresh.
  assign mem_raddr = hit ? hit_idx : raddr[IDX_W-1:0];

  ekbt_mem u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(mem_raddr), .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = hit_idx;
    wdata = '{key: cur_key, expiry: cur_now + lifetime_seconds};
    if (fin_go && cur_op == OP_ADD) begin
      if (hit) begin
        we = 1'b1;
        wdata.key = rdata.key; // keep the stored key, refresh the expiry
      end else if (count < cap_eff && free) begin
        we = 1'b1;
        waddr = free_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      capacity_limit <= 7'd64;
      lifetime_seconds <= 32'd0;
      key_bytes <= 4'd8;
      valid <= '0;
      count <= '0;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      hit <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        case (cfg_idx)
          REG_CAPACITY: capacity_limit <= pwdata[6:0];
          REG_LIFETIME: lifetime_seconds <= pwdata;
          REG_KEYBYTES: key_bytes <= pwdata[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cur_op  <= op;
            cur_key <= key & mask;
            cur_now <= now_seconds;
            raddr   <= '0;
            rd_vld  <= 1'b0;
            hit     <= 1'b0;
            free    <= 1'b0;
            removed <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Issue next read, evaluate the previous one.
          rd_vld <= !raddr[IDX_W];
          ridx   <= raddr[IDX_W-1:0];
          if (!raddr[IDX_W]) raddr <= raddr + 1'b1;
          if (rd_vld) begin
            if (!valid[ridx] && !free) begin
              free <= 1'b1;
              free_idx <= ridx;
            end
            if (cur_op == OP_EXPIRE) begin
              if (valid[ridx] && rdata.expiry <= cur_now) begin
                valid[ridx] <= 1'b0;
                removed <= removed + 1'b1;
              end
            end else if (match && !hit) begin
              hit <= 1'b1;
              hit_idx <= ridx;
              raddr <= {1'b0, ridx}; // re-read hit entry for its stored key
            end
          end
          if (rd_vld && ridx == IDX_W'(TABLE_DEPTH - 1) &&
              !(match && !hit && cur_op != OP_EXPIRE))
            state <= S_FIN;
          else if (!rd_vld && raddr[IDX_W]) state <= S_FIN;
          if (hit && cur_op != OP_EXPIRE) begin
            rd_vld <= 1'b0;
            raddr <= {1'b1, {IDX_W{1'b0}}};
          end
        end
        S_FIN: begin
          if (fin_go) begin
            status <= 1'b0;
            found <= 1'b0;
            removed_count <= 7'd0;
            occupancy <= 7'(count);
            case (cur_op)
              OP_ADD: begin
                if (!hit) begin
                  if (count < cap_eff && free) begin
                    valid[free_idx] <= 1'b1;
                    occupancy <= 7'(count + 1'b1);
                    count <= count + 1'b1;
                  end else status <= 1'b1;
                end
              end
              OP_QUERY: found <= hit;
              OP_EXPIRE: begin
                removed_count <= 7'(removed);
                count <= count - removed;
                occupancy <= 7'(count - removed);
              end
              default: ;
            endcase
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> out_valid) else $error("no result after item");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= TABLE_DEPTH) else $error("count over depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
`endif
endmodule
